// File: rtl/pal_pkg.sv
// Shared types and constants for the positional array list.
`default_nettype none

package pal_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 6;
  localparam int USED_W     = $clog2(DEPTH + 1);
  localparam int CMP_W      = (USED_W > POS_W) ? USED_W : POS_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - COUNT_W - DATA_W;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // per-cell controls for one cycle
  typedef struct packed {
    logic load;        // take the inserted word
    logic take_left;   // take lower neighbor (insert shift)
    logic take_right;  // take upper neighbor (delete shift)
    logic hit;         // addressed by the current request position
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/positional_array_list.sv
// Top level of the positional array list: request decode, cell row, result register.
// A result is registered at its request transfer and shown in the cycle after it.
// Throughput: one request per cycle while the input side is not stalled; every cell of
//   the row shifts in the same cycle, so an insert or delete costs the same whatever the position.
// The input side stalls while a result waits and out_tready is low, and during reset.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
//   stored words are not cleared and are never read before being written.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tuser: [1:0] op
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // in_tdata: [5:0] position, [37:6] value, [39:38] zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tuser: [1:0] status
  output logic      [OUT_USER_W-1:0] out_tuser,
  // out_tdata: [31:0] read_value, [37:32] count, [39:38] zero pad
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  // request fields
  op_t               req_op;
  logic [POS_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_value;

  assign req_op    = op_t'(in_tuser);
  assign req_pos   = in_tdata[0 +: POS_W];
  assign req_value = in_tdata[POS_W +: DATA_W];

  logic [USED_W-1:0] used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [USED_W-1:0] out_used_r;

  logic              in_xfer;
  status_t           status;
  logic              do_ins, do_del, do_read;
  logic [CMP_W-1:0]  pos_w, used_w;

  // result register frees up when it is empty or being drained; nothing taken in reset
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  assign pos_w  = CMP_W'(req_pos);
  assign used_w = CMP_W'(used_r);

  // check order: insert looks at full before position, delete at empty before position
  always_comb begin
    status = ST_OK;
    case (req_op)
      OP_GET: begin
        if (pos_w >= used_w) status = ST_BADPOS;
      end
      OP_INSERT: begin
        if (used_r == USED_W'(DEPTH)) status = ST_FULL;
        else if (pos_w > used_w)      status = ST_BADPOS;
      end
      OP_DELETE: begin
        if (used_r == '0)             status = ST_EMPTY;
        else if (pos_w >= used_w)     status = ST_BADPOS;
      end
      default: begin
        status = ST_BADPOS;
      end
    endcase
  end

  assign do_ins  = in_xfer && (req_op == OP_INSERT) && (status == ST_OK);
  assign do_del  = in_xfer && (req_op == OP_DELETE) && (status == ST_OK);
  assign do_read = ((req_op == OP_GET) || (req_op == OP_DELETE)) && (status == ST_OK);

  // cell row: insert shifts cells from pos upward up, delete pulls cells from pos upward down
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_rd   [DEPTH];
  cell_ctrl_t        cell_ctrl [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cells
    logic [DATA_W-1:0] left_d, right_d;

    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
    end

    assign cell_ctrl[k].load       = do_ins && (pos_w == CMP_W'(k));
    assign cell_ctrl[k].take_left  = do_ins && (CMP_W'(k) > pos_w);
    assign cell_ctrl[k].take_right = do_del && (CMP_W'(k) >= pos_w);
    assign cell_ctrl[k].hit        = (pos_w == CMP_W'(k));

    pal_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[k]),
      .ins_data   (req_value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[k]),
      .rd_data    (cell_rd[k])
    );
  end

  // read: at most one cell is addressed, so OR of all read outputs
  logic [DATA_W-1:0] rd_any;
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (do_ins)      used_nxt = used_r + USED_W'(1);
    else if (do_del) used_nxt = used_r - USED_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on each request transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_status_r <= status;
      out_rd_r     <= do_read ? rd_any : '0;
      out_used_r   <= used_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, COUNT_W'(out_used_r), out_rd_r};

endmodule

`default_nettype wire

// File: rtl/pal_cell.sv
// One list slot: holds a word and moves it to or from its neighbors.
`default_nettype none

module pal_cell
  import pal_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] ins_data,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  output logic      [DATA_W-1:0] data,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data_r <= ins_data;
    end else if (ctrl.take_left) begin
      data_r <= left_data;
    end else if (ctrl.take_right) begin
      data_r <= right_data;
    end
  end

  assign data    = data_r;
  // zero when not addressed so the top can OR all cells together
  assign rd_data = ctrl.hit ? data_r : '0;

endmodule

`default_nettype wire
